### hw/rtl/sso_pkg.sv
package sso_pkg;

  localparam int FUNC_W    = 2;
  localparam int FREQ_W    = 14;
  localparam int SAMPLE_W  = 16;
  localparam int AMP_W     = 15;
  localparam int PHASE_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam logic [FREQ_W-1:0] FREQ_UP_LIMIT   = 14'd15800;
  localparam logic [FREQ_W-1:0] FREQ_DOWN_LIMIT = 14'd10;
  localparam logic [FREQ_W-1:0] FREQ_UP_STEP    = 14'd2;
  localparam logic [FREQ_W-1:0] FREQ_DOWN_STEP  = 14'd5;

  localparam logic [PHASE_W-1:0] PHASE_PER_HZ_RESET = 32'd89478;
  localparam logic [FREQ_W-1:0]  START_FREQ_RESET   = 14'd440;
  localparam logic [AMP_W-1:0]   AMPLITUDE_RESET    = 15'd16384;
  localparam logic [PHASE_W-1:0] PHASE_STEP_RESET   = 32'(64'd440 * 64'd89478);

  // pi in Q32
  localparam logic [63:0] PI_Q32 = 64'd13493037704;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_RAISE  = 2'd1,
    FUNC_LOWER  = 2'd2,
    FUNC_RELOAD = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_UP     = 2'd1,
    KIND_DOWN   = 2'd2,
    KIND_RELOAD = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_PER_HZ    = 2'd0,
    CFG_START_FREQUENCY = 2'd1,
    CFG_AMPLITUDE       = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    func_t func;
    logic  wave_on;
  } tick_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [FREQ_W-1:0]          frequency_now;
  } wave_item_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  wave_on;
  } cmd_t;

endpackage

### hw/rtl/sso_front.sv
module sso_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick_valid,
  output logic                tick_stall,
  input  sso_pkg::tick_item_t tick_item,
  output sso_pkg::cmd_t       cmd,
  input  logic                cmd_pop
);

  localparam int QDEPTH = 2;

  sso_pkg::kind_t kind_dec;
  sso_pkg::cmd_t  q_mem [QDEPTH];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  always_comb begin
    unique case (tick_item.func)
      sso_pkg::FUNC_TICK:   kind_dec = sso_pkg::KIND_TICK;
      sso_pkg::FUNC_RAISE:  kind_dec = sso_pkg::KIND_UP;
      sso_pkg::FUNC_LOWER:  kind_dec = sso_pkg::KIND_DOWN;
      sso_pkg::FUNC_RELOAD: kind_dec = sso_pkg::KIND_RELOAD;
      default:              kind_dec = sso_pkg::KIND_TICK;
    endcase
  end

  assign tick_stall = (count == 2'(QDEPTH));
  assign push       = tick_valid && !tick_stall;
  assign pop        = cmd_pop && (count != 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr].valid   <= 1'b1;
      q_mem[wr_ptr].kind    <= kind_dec;
      q_mem[wr_ptr].wave_on <= (kind_dec == sso_pkg::KIND_TICK) && tick_item.wave_on;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_comb begin
    cmd       = q_mem[rd_ptr];
    cmd.valid = (count != 2'd0);
  end

endmodule

### hw/rtl/sso_sine_rom.sv
module sso_sine_rom #(
  parameter int TABLE_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rd_en,
  input  logic [TABLE_BITS-1:0]              addr,
  output logic signed [sso_pkg::SAMPLE_W-1:0] data
);

  localparam int SIZE    = 1 << TABLE_BITS;
  localparam int QUARTER = 1 << (TABLE_BITS - 2);

  // shift-subtract quotient, evaluated only while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // round(32767 * sin(r * pi/2 / QUARTER)), Q31 Taylor series
  function automatic logic signed [sso_pkg::SAMPLE_W-1:0] quarter_sine(input logic [15:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] v;
    logic [63:0] den;
    x    = (64'(r) * sso_pkg::PI_Q32 + (64'd1 << (TABLE_BITS - 1))) >> TABLE_BITS;
    x2   = (x * x) >> 31;
    term = x;
    pos  = x;
    neg  = 64'd0;
    for (int n = 1; n < 16; n++) begin
      den  = 64'((2 * n) * (2 * n + 1));
      term = udiv64((term * x2) >> 31, den);
      if ((n & 1) == 1) neg = neg + term;
      else pos = pos + term;
    end
    s = (pos > neg) ? pos - neg : 64'd0;
    if (s > (64'd1 << 31)) s = 64'd1 << 31;
    v = (s * 64'd32767 + (64'd1 << 30)) >> 31;
    return v[sso_pkg::SAMPLE_W-1:0];
  endfunction

  logic signed [sso_pkg::SAMPLE_W-1:0] tab [SIZE];

  for (genvar j = 0; j < SIZE; j++) begin : g_tab
    localparam int Q = j >> (TABLE_BITS - 2);
    localparam int R = j & (QUARTER - 1);
    localparam logic signed [sso_pkg::SAMPLE_W-1:0] V =
      ((Q & 1) == 1) ? quarter_sine(16'(QUARTER - R)) : quarter_sine(16'(R));
    assign tab[j] = ((Q & 2) == 2) ? -V : V;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data <= tab[addr];
    end
  end

endmodule

### hw/rtl/sso_back.sv
module sso_back #(
  parameter int TABLE_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sso_pkg::cmd_t                       cmd,
  output logic                                cmd_pop,
  input  logic [sso_pkg::PHASE_W-1:0]         phase_per_hz,
  input  logic [sso_pkg::FREQ_W-1:0]          start_frequency,
  input  logic [sso_pkg::AMP_W-1:0]           amplitude,
  output logic                                wave_valid,
  input  logic                                wave_stall,
  output sso_pkg::wave_item_t                 wave_item
);

  localparam int OQ_DEPTH = 4;

  logic [sso_pkg::PHASE_W-1:0] phase_acc;
  logic [sso_pkg::PHASE_W-1:0] phase_step;
  logic [sso_pkg::FREQ_W-1:0]  tone_hz;
  logic [sso_pkg::FREQ_W-1:0]  tone_next;

  logic                        s1_valid;
  logic                        s1_on;
  logic [sso_pkg::FREQ_W-1:0]  s1_freq;
  logic signed [sso_pkg::SAMPLE_W-1:0] rom_q;

  logic signed [sso_pkg::SAMPLE_W+sso_pkg::AMP_W:0] prod;
  sso_pkg::wave_item_t         result;

  sso_pkg::wave_item_t         oq [OQ_DEPTH];
  logic [1:0]                  oq_wr;
  logic [1:0]                  oq_rd;
  logic [2:0]                  oq_count;
  logic                        oq_pop;
  logic                        credit;
  logic                        do_tick;
  logic                        do_event;

  assign credit   = (oq_count + 3'(s1_valid)) < 3'(OQ_DEPTH);
  assign do_tick  = cmd.valid && (cmd.kind == sso_pkg::KIND_TICK) && credit;
  assign do_event = cmd.valid && (cmd.kind != sso_pkg::KIND_TICK);
  assign cmd_pop  = do_tick || do_event;

  always_comb begin
    case (cmd.kind)
      sso_pkg::KIND_UP:
        tone_next = (tone_hz < sso_pkg::FREQ_UP_LIMIT) ? tone_hz + sso_pkg::FREQ_UP_STEP
                                                      : tone_hz;
      sso_pkg::KIND_DOWN:
        tone_next = (tone_hz > sso_pkg::FREQ_DOWN_LIMIT) ? tone_hz - sso_pkg::FREQ_DOWN_STEP
                                                        : tone_hz;
      sso_pkg::KIND_RELOAD:
        tone_next = start_frequency;
      default:
        tone_next = tone_hz;
    endcase
  end

  sso_sine_rom #(
    .TABLE_BITS(TABLE_BITS)
  ) u_rom (
    .clk  (clk),
    .rd_en(do_tick),
    .addr (phase_acc[sso_pkg::PHASE_W-1 -: TABLE_BITS]),
    .data (rom_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc  <= '0;
      tone_hz    <= sso_pkg::START_FREQ_RESET;
      phase_step <= sso_pkg::PHASE_STEP_RESET;
      s1_valid   <= 1'b0;
    end else begin
      s1_valid <= do_tick;
      if (do_event) begin
        tone_hz    <= tone_next;
        phase_acc  <= '0;
        phase_step <= 32'(46'(tone_next) * 46'(phase_per_hz));
      end else if (do_tick) begin
        phase_acc <= cmd.wave_on ? phase_acc + phase_step : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_tick) begin
      s1_on   <= cmd.wave_on;
      s1_freq <= tone_hz;
    end
  end

  // arithmetic shift floors, as the sample definition requires
  assign prod = rom_q * $signed({1'b0, amplitude});

  always_comb begin
    result.sample        = s1_on ? sso_pkg::SAMPLE_W'(prod >>> 15) : '0;
    result.frequency_now = s1_freq;
  end

  assign wave_valid = (oq_count != 3'd0);
  assign oq_pop     = wave_valid && !wave_stall;
  assign wave_item  = oq[oq_rd];

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      oq[oq_wr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      if (s1_valid) oq_wr <= oq_wr + 2'd1;
      if (oq_pop)   oq_rd <= oq_rd + 2'd1;
      oq_count <= oq_count + 3'(s1_valid) - 3'(oq_pop);
    end
  end

endmodule

### hw/rtl/stepped_sine_oscillator.sv
// A tick's sample passes the front queue, the registered ROM read and the output queue before it is offered.
// Throughput: one item per cycle, ticks only while the output queue has room; events give no sample.
// Ticks pace on the four-entry output queue; the sine ROM read is registered.
// Reset (rst, synchronous): queues empty, phase 0, frequency 440 Hz, registers
// at their defaults and the phase step set to 440 times the default step.
module stepped_sine_oscillator #(
  parameter int TABLE_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                tick_valid,
  output logic                                tick_stall,
  input  sso_pkg::tick_item_t                 tick_item,
  output logic                                wave_valid,
  input  logic                                wave_stall,
  output sso_pkg::wave_item_t                 wave_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sso_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sso_pkg::CFG_DAT_W-1:0]       cfg_data
);

  logic [sso_pkg::PHASE_W-1:0] phase_per_hz;
  logic [sso_pkg::FREQ_W-1:0]  start_frequency;
  logic [sso_pkg::AMP_W-1:0]   amplitude;
  sso_pkg::cmd_t               cmd;
  logic                        cmd_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_per_hz    <= sso_pkg::PHASE_PER_HZ_RESET;
      start_frequency <= sso_pkg::START_FREQ_RESET;
      amplitude       <= sso_pkg::AMPLITUDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sso_pkg::CFG_PHASE_PER_HZ:    phase_per_hz    <= cfg_data[sso_pkg::PHASE_W-1:0];
        sso_pkg::CFG_START_FREQUENCY: start_frequency <= cfg_data[sso_pkg::FREQ_W-1:0];
        sso_pkg::CFG_AMPLITUDE:       amplitude       <= cfg_data[sso_pkg::AMP_W-1:0];
        default: ;
      endcase
    end
  end

  sso_front u_front (
    .clk       (clk),
    .rst       (rst),
    .tick_valid(tick_valid),
    .tick_stall(tick_stall),
    .tick_item (tick_item),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  sso_back #(
    .TABLE_BITS(TABLE_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .phase_per_hz   (phase_per_hz),
    .start_frequency(start_frequency),
    .amplitude      (amplitude),
    .wave_valid     (wave_valid),
    .wave_stall     (wave_stall),
    .wave_item      (wave_item)
  );

endmodule

### tb/sso_checker.sv
`timescale 1ns / 1ps

module sso_checker
  import sso_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tick_valid,
  input  logic                 tick_stall,
  input  tick_item_t           tick_item,
  input  logic                 wave_valid,
  input  logic                 wave_stall,
  input  wave_item_t           wave_item,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output int                   outstanding,
  output int                   fail_count
);

  localparam int ROM_BITS = 10;
  localparam int ROM_SIZE = 1 << ROM_BITS;
  localparam int QUARTER  = 1 << (ROM_BITS - 2);

  logic signed [SAMPLE_W-1:0] sine_rom [0:ROM_SIZE-1];

  logic [PHASE_W-1:0] step_per_hz;
  logic [FREQ_W-1:0]  start_hz;
  logic [AMP_W-1:0]   gain;
  logic [PHASE_W-1:0] phase;
  logic [FREQ_W-1:0]  tone;
  logic [PHASE_W-1:0] step;

  wave_item_t wave_q[$];

  initial begin
    outstanding = 0;
    fail_count  = 0;
  end

  // round(32767 * sin(r * (pi/2) / QUARTER)), Taylor series in Q31
  function automatic int quarter_wave(int unsigned r);
    longint unsigned rr, x, x2, term, pos, neg, s, div;
    int unsigned n;
    rr   = r;
    x    = (rr * PI_Q32 + (64'd1 << (ROM_BITS - 1))) >> ROM_BITS;
    x2   = (x * x) >> 31;
    term = x;
    pos  = x;
    neg  = 0;
    for (n = 1; n < 16 && term != 0; n++) begin
      div  = (2 * n) * (2 * n + 1);
      term = ((term * x2) >> 31) / div;
      if (n[0]) neg += term;
      else pos += term;
    end
    s = (pos > neg) ? pos - neg : 64'd0;
    if (s > (64'd1 << 31)) s = 64'd1 << 31;
    return int'((s * 64'd32767 + (64'd1 << 30)) >> 31);
  endfunction

  initial begin
    int j, q, r, v;
    for (j = 0; j < ROM_SIZE; j++) begin
      q = j >> (ROM_BITS - 2);
      r = j & (QUARTER - 1);
      v = ((q & 1) != 0) ? quarter_wave(QUARTER - r) : quarter_wave(r);
      sine_rom[j] = ((q & 2) != 0) ? SAMPLE_W'(-v) : SAMPLE_W'(v);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < 100)
      $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic retune();
    phase = '0;
    step  = step_per_hz * PHASE_W'(tone);
  endtask

  task automatic step_oscillator(input tick_item_t it);
    logic [ROM_BITS-1:0] idx;
    int                  prod;
    int                  s;
    wave_item_t          w;
    case (it.func)
      FUNC_RAISE: begin
        if (tone < FREQ_UP_LIMIT) tone = tone + FREQ_UP_STEP;
        retune();
      end
      FUNC_LOWER: begin
        if (tone > FREQ_DOWN_LIMIT) tone = tone - FREQ_DOWN_STEP;
        retune();
      end
      FUNC_RELOAD: begin
        tone = start_hz;
        retune();
      end
      default: begin
        s = 0;
        if (it.wave_on) begin
          idx   = phase[PHASE_W-1 -: ROM_BITS];
          prod  = int'(sine_rom[idx]) * int'(gain);
          s     = prod >>> 15;
          phase = phase + step;
        end else begin
          phase = '0;
        end
        w.sample        = SAMPLE_W'(s);
        w.frequency_now = tone;
        wave_q.push_back(w);
      end
    endcase
  endtask

  always @(posedge clk) begin : track
    wave_item_t want;
    if (rst) begin
      step_per_hz = PHASE_PER_HZ_RESET;
      start_hz    = START_FREQ_RESET;
      gain        = AMPLITUDE_RESET;
      tone        = START_FREQ_RESET;
      retune();
      wave_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PHASE_PER_HZ:    step_per_hz = cfg_data;
          CFG_START_FREQUENCY: start_hz    = cfg_data[FREQ_W-1:0];
          CFG_AMPLITUDE:       gain        = cfg_data[AMP_W-1:0];
          default: ;
        endcase
      end
      if (tick_valid && !tick_stall) step_oscillator(tick_item);
      if (wave_valid && !wave_stall) begin
        if (wave_q.size() == 0) begin
          report_mismatch("unexpected sample", int'(wave_item.sample), 0);
        end else begin
          want = wave_q.pop_front();
          if (wave_item.sample !== want.sample)
            report_mismatch("sample", int'(wave_item.sample), int'(want.sample));
          if (wave_item.frequency_now !== want.frequency_now)
            report_mismatch("frequency_now", int'(wave_item.frequency_now),
                            int'(want.frequency_now));
        end
      end
      outstanding <= wave_q.size();
    end
  end

endmodule

### tb/tb_stepped_sine_oscillator.sv
`timescale 1ns / 1ps

module tb_stepped_sine_oscillator;
  import sso_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_COMB
  } rx_mode_t;

  logic                 clk;
  logic                 rst;
  logic                 tick_valid;
  logic                 tick_stall;
  tick_item_t           tick_item;
  logic                 wave_valid;
  logic                 wave_stall;
  wave_item_t           wave_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  int       outstanding;
  int       fail_count;
  int       burst_left;
  rx_mode_t stall_mode;
  logic [7:0] stall_cycle;

  stepped_sine_oscillator i_dut (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .tick_item  (tick_item),
    .wave_valid (wave_valid),
    .wave_stall (wave_stall),
    .wave_item  (wave_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  sso_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .tick_valid  (tick_valid),
    .tick_stall  (tick_stall),
    .tick_item   (tick_item),
    .wave_valid  (wave_valid),
    .wave_stall  (wave_stall),
    .wave_item   (wave_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver stall pattern, re-picked each time stall_cycle[5:0] returns to zero
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 8'd1;
    if (stall_cycle[5:0] == 6'd0) stall_mode <= rx_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      RX_OPEN:  wave_stall <= 1'b0;
      RX_LIGHT: wave_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: wave_stall <= ($urandom_range(0, 3) != 0);
      default:  wave_stall <= (stall_cycle[2:0] < 3'd3);
    endcase
  end

  task automatic send_tick(input func_t f, input logic on);
    tick_item_t it;
    int         gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        tick_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    it.func    = f;
    it.wave_on = on;
    tick_valid <= 1'b1;
    tick_item  <= it;
    @(posedge clk);
    while (tick_stall) @(posedge clk);
  endtask

  // hold off until every sample is back and any event has drained
  task automatic settle();
    tick_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] pph, input logic [13:0] sf,
                          input logic [14:0] amp, input logic spare);
    if (spare) cfg_write(CFG_SPARE_INDEX, $urandom());
    cfg_write(CFG_PHASE_PER_HZ, pph);
    cfg_write(CFG_START_FREQUENCY, {18'($urandom_range(0, 262143)), sf});
    cfg_write(CFG_AMPLITUDE, {17'($urandom_range(0, 131071)), amp});
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_config();
    logic [31:0] pph;
    logic [13:0] sf;
    logic [14:0] amp;
    case ($urandom_range(0, 5))
      0:       pph = 32'd1;
      1:       pph = '1;
      2:       pph = '0;
      3:       pph = $urandom_range(20000, 200000);
      default: pph = $urandom();
    endcase
    case ($urandom_range(0, 8))
      0:       sf = 14'd6;
      1:       sf = 14'd15801;
      2:       sf = 14'($urandom_range(15780, 15801));
      3:       sf = 14'($urandom_range(6, 20));
      4:       sf = 14'($urandom());
      5:       sf = ($urandom_range(0, 1) == 0) ? 14'd0 : 14'h3fff;
      default: sf = 14'($urandom_range(20, 4000));
    endcase
    case ($urandom_range(0, 4))
      0:       amp = '0;
      1:       amp = '1;
      default: amp = 15'($urandom());
    endcase
    set_regs(pph, sf, amp, $urandom_range(0, 2) == 0);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 72)      send_tick(FUNC_TICK, 1'b1);
    else if (r < 80) send_tick(FUNC_TICK, 1'b0);
    else if (r < 88) send_tick(FUNC_RAISE, 1'($urandom_range(0, 1)));
    else if (r < 96) send_tick(FUNC_LOWER, 1'($urandom_range(0, 1)));
    else             send_tick(FUNC_RELOAD, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int ph, k;
    rst         = 1'b1;
    tick_valid  = 1'b0;
    tick_item   = '0;
    wave_stall  = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    burst_left  = 0;
    stall_mode  = RX_OPEN;
    stall_cycle = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // defaults from reset
    send_tick(FUNC_TICK, 1'b1);
    send_tick(FUNC_TICK, 1'b1);
    send_tick(FUNC_TICK, 1'b0);
    send_tick(FUNC_TICK, 1'b1);
    send_tick(FUNC_RAISE, 1'b0);
    send_tick(FUNC_TICK, 1'b1);
    send_tick(FUNC_LOWER, 1'b1);
    send_tick(FUNC_RELOAD, 1'b0);
    send_tick(FUNC_TICK, 1'b1);

    // full scale, backward phase, raise across the upper limit
    settle();
    set_regs('1, 14'd15799, '1, 1'b1);
    send_tick(FUNC_TICK, 1'b1);
    send_tick(FUNC_RELOAD, 1'b1);
    send_tick(FUNC_TICK, 1'b1);
    send_tick(FUNC_TICK, 1'b1);
    send_tick(FUNC_RAISE, 1'b1);
    send_tick(FUNC_TICK, 1'b1);
    send_tick(FUNC_RAISE, 1'b0);
    send_tick(FUNC_TICK, 1'b1);

    // frozen phase, lower down to and past the lower limit
    settle();
    set_regs('0, 14'd11, '1, 1'b0);
    send_tick(FUNC_RELOAD, 1'b1);
    send_tick(FUNC_LOWER, 1'b0);
    send_tick(FUNC_LOWER, 1'b1);
    send_tick(FUNC_RAISE, 1'b1);
    send_tick(FUNC_TICK, 1'b1);

    // start frequency out of range, zero gain
    settle();
    set_regs(32'd3, 14'h3fff, '0, 1'b0);
    send_tick(FUNC_RELOAD, 1'b0);
    send_tick(FUNC_RAISE, 1'b1);
    send_tick(FUNC_LOWER, 1'b1);
    send_tick(FUNC_TICK, 1'b1);
    send_tick(FUNC_TICK, 1'b1);

    for (ph = 0; ph < 12; ph++) begin
      settle();
      pick_config();
      send_tick(FUNC_RELOAD, 1'($urandom_range(0, 1)));
      for (k = 0; k < 119; k++) random_item();
    end

    settle();
    @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/sso_pkg.sv
hw/rtl/sso_front.sv
hw/rtl/sso_sine_rom.sv
hw/rtl/sso_back.sv
hw/rtl/stepped_sine_oscillator.sv
tb/sso_checker.sv
tb/tb_stepped_sine_oscillator.sv
